FILE: rtl/core/oaa_pkg.sv
// Shared constants, types and fixed-point coefficients for the octant atan2 block.
// No dependencies; every other file refers to it by scoped names.
package oaa_pkg;

	// Default parameter values
	localparam int COORD_WIDTH_DEF = 16;
	localparam int ANGLE_FRAC_DEF  = 13;

	// Output angle width, signed Q2.F
	localparam int ANGLE_W = 16;

	// Ratio min/max in unsigned Q1.16
	localparam int RATIO_FRAC = 16;
	localparam int RATIO_W    = RATIO_FRAC + 1;

	// Polynomial coefficients, unsigned Q1.30: pi/4 + 0.273 and 0.273
	localparam logic [30:0] COEF_A = 31'd1136446374;
	localparam logic [28:0] COEF_B = 29'd293131518;

	// (COEF_A << 16) - COEF_B * r, split in two halves for the second product
	localparam int BQ_W    = 29 + RATIO_W;
	localparam int T_W     = 31 + RATIO_FRAC;
	localparam int T_SPLIT = 24;
	localparam int PROD_W  = 64;

	// Fold offsets, Q61, truncated
	localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
	localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
	localparam int          Q61_FRAC    = 61;

	// Buffering between front and back, and stages after the divider
	localparam int QUEUE_DEPTH = 2;
	localparam int POLY_STAGES = 6;

	// Octant code: {x negative, y negative, |x| <= |y|}
	typedef enum logic [2:0] {
		OCT_POS_FLAT    = 3'b000,
		OCT_POS_STEEP   = 3'b001,
		OCT_NEGY_FLAT   = 3'b010,
		OCT_NEGY_STEEP  = 3'b011,
		OCT_NEGX_FLAT   = 3'b100,
		OCT_NEGX_STEEP  = 3'b101,
		OCT_NEGXY_FLAT  = 3'b110,
		OCT_NEGXY_STEEP = 3'b111
	} oct_t;

endpackage

FILE: rtl/core/oaa_coord_if.sv
// Coordinate channel: valid/ready handshake carrying a signed (y, x) pair.
// Depends on oaa_pkg for the default coordinate width.
interface oaa_coord_if #(
	parameter int COORD_WIDTH = oaa_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_x;

	modport source (output valid, output coord_y, output coord_x, input ready);
	modport sink   (input valid, input coord_y, input coord_x, output ready);
endinterface

FILE: rtl/core/oaa_angle_if.sv
// Angle channel: valid/ready handshake carrying a signed Q2.F angle.
// Depends on oaa_pkg for the angle width.
interface oaa_angle_if ();
	logic                              valid;
	logic                              ready;
	logic signed [oaa_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink   (input valid, input angle, output ready);
endinterface

FILE: rtl/core/oaa_front.sv
// Front part: accepts coordinate pairs, forms magnitudes, octant code and min/max.
// Depends on oaa_pkg and oaa_coord_if.
module oaa_front #(
	parameter int COORD_WIDTH = oaa_pkg::COORD_WIDTH_DEF,
	localparam int ITEM_W     = 2 * COORD_WIDTH + 1 + $bits(oaa_pkg::oct_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	oaa_coord_if.sink         coords,
	output logic              item_vld,
	input  logic              item_rdy,
	output logic [ITEM_W-1:0] item
);

	typedef struct packed {
		logic                   zero;
		oaa_pkg::oct_t          oct;
		logic [COORD_WIDTH-1:0] mn;
		logic [COORD_WIDTH-1:0] mx;
	} item_t;

	logic [COORD_WIDTH-1:0] yraw;
	logic [COORD_WIDTH-1:0] xraw;
	logic [COORD_WIDTH-1:0] ay;
	logic [COORD_WIDTH-1:0] ax;
	logic                   yneg;
	logic                   xneg;
	logic                   steep;
	logic                   accept;
	item_t                  cls;
	item_t                  item_q;
	logic                   vld_q;

	assign yraw = coords.coord_y;
	assign xraw = coords.coord_x;
	assign yneg = yraw[COORD_WIDTH-1];
	assign xneg = xraw[COORD_WIDTH-1];

	// Most negative value maps to 2^(W-1), still exact in W unsigned bits
	assign ay    = yneg ? (COORD_WIDTH'(0) - yraw) : yraw;
	assign ax    = xneg ? (COORD_WIDTH'(0) - xraw) : xraw;
	assign steep = (ax <= ay);

	always_comb begin
		cls.oct  = oaa_pkg::oct_t'({xneg, yneg, steep});
		cls.mn   = steep ? ax : ay;
		cls.mx   = steep ? ay : ax;
		cls.zero = (ax == '0) && (ay == '0);
	end

	assign coords.ready = !vld_q || item_rdy;
	assign accept       = coords.valid && coords.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (item_rdy) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cls;
		end
	end

	assign item_vld = vld_q;
	assign item     = item_q;

endmodule

FILE: rtl/core/oaa_queue.sv
// Small FIFO that decouples the front part from the back part.
// Depends on oaa_pkg for the default depth; DEPTH must be a power of two.
module oaa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = oaa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_vld,
	output logic             push_rdy,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_vld,
	input  logic             pop_rdy,
	output logic [WIDTH-1:0] pop_data
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign push_rdy = (count_q != (AW + 1)'(DEPTH));
	assign pop_vld  = (count_q != '0);
	assign push     = push_vld && push_rdy;
	assign pop      = pop_vld && pop_rdy;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW + 1)'(push) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/oaa_back.sv
// Back part: pipelined restoring divider, polynomial, octant fold, rounding, output register.
// Depends on oaa_pkg and oaa_angle_if.
module oaa_back #(
	parameter int COORD_WIDTH     = oaa_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = oaa_pkg::ANGLE_FRAC_DEF,
	localparam int ITEM_W         = 2 * COORD_WIDTH + 1 + $bits(oaa_pkg::oct_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_vld,
	output logic              item_rdy,
	input  logic [ITEM_W-1:0] item,
	oaa_angle_if.source       result
);

	localparam int W     = COORD_WIDTH;
	localparam int RW    = oaa_pkg::RATIO_W;
	localparam int AW    = oaa_pkg::ANGLE_W;
	localparam int SH    = oaa_pkg::Q61_FRAC - ANGLE_FRAC_BITS;
	localparam int SUM_W = (SH + AW > oaa_pkg::PROD_W + 1) ? SH + AW : oaa_pkg::PROD_W + 1;
	localparam int TH_W  = oaa_pkg::T_W - oaa_pkg::T_SPLIT;
	localparam int PH_W  = TH_W + RW;
	localparam int PL_W  = oaa_pkg::T_SPLIT + RW;
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (SH - 1);

	typedef struct packed {
		logic          zero;
		oaa_pkg::oct_t oct;
		logic [W-1:0]  mn;
		logic [W-1:0]  mx;
	} item_t;

	item_t in_item;
	logic  adv;

	assign in_item  = item;
	assign adv      = !result.valid || result.ready;
	assign item_rdy = adv;

	// Divider: one quotient bit per stage, MSB first
	logic          dv_vld_s  [RW];
	logic [W-1:0]  dv_rem_s  [RW];
	logic [W-1:0]  dv_mx_s   [RW];
	logic [RW-1:0] dv_quo_s  [RW];
	oaa_pkg::oct_t dv_oct_s  [RW];
	logic          dv_zero_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_div
		logic [W-1:0]  rem_in;
		logic [W-1:0]  mx_in;
		logic [RW-1:0] quo_in;
		oaa_pkg::oct_t oct_in;
		logic          zero_in;
		logic          vld_in;
		logic          ge;

		if (j == 0) begin : g_first
			assign rem_in  = in_item.mn;
			assign mx_in   = in_item.mx;
			assign quo_in  = '0;
			assign oct_in  = in_item.oct;
			assign zero_in = in_item.zero;
			assign vld_in  = item_vld;
		end else begin : g_next
			// Remainder stays below the divisor, so the top bit is free to shift out
			assign rem_in  = {dv_rem_s[j-1][W-2:0], 1'b0};
			assign mx_in   = dv_mx_s[j-1];
			assign quo_in  = dv_quo_s[j-1];
			assign oct_in  = dv_oct_s[j-1];
			assign zero_in = dv_zero_s[j-1];
			assign vld_in  = dv_vld_s[j-1];
		end

		assign ge = (rem_in >= mx_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[j]  <= ge ? (rem_in - mx_in) : rem_in;
				dv_mx_s[j]   <= mx_in;
				dv_quo_s[j]  <= {quo_in[RW-2:0], ge};
				dv_oct_s[j]  <= oct_in;
				dv_zero_s[j] <= zero_in;
			end
		end
	end

	// Polynomial and fold stages
	logic                         vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [RW-1:0]                r_s1, r_s2;
	logic [oaa_pkg::BQ_W-1:0]     bq_s1;
	logic [oaa_pkg::T_W-1:0]      t_s2;
	logic [PH_W-1:0]              ph_s3;
	logic [PL_W-1:0]              pl_s3;
	logic [oaa_pkg::PROD_W-2:0]   p_s4;
	logic [oaa_pkg::PROD_W-1:0]   mag_s5;
	logic                         neg_s5, neg_s6;
	logic [AW-1:0]                q_s6;
	oaa_pkg::oct_t                oct_s1, oct_s2, oct_s3, oct_s4;
	logic                         zero_s1, zero_s2, zero_s3, zero_s4;
	logic                         out_vld_q;
	logic [AW-1:0]                angle_q;

	logic [oaa_pkg::PROD_W-1:0]   prod;
	logic [oaa_pkg::PROD_W-1:0]   fold_off;
	logic                         fold_add;
	logic                         fold_neg;
	logic [oaa_pkg::PROD_W-1:0]   fold_mag;
	logic [SUM_W-1:0]             rnd;

	assign prod = {ph_s3, oaa_pkg::T_SPLIT'(0)} + oaa_pkg::PROD_W'(pl_s3);

	always_comb begin
		unique case (oct_s4)
			oaa_pkg::OCT_POS_FLAT: begin
				fold_off = '0;                   fold_add = 1'b1; fold_neg = 1'b0;
			end
			oaa_pkg::OCT_POS_STEEP: begin
				fold_off = oaa_pkg::HALF_PI_Q61; fold_add = 1'b0; fold_neg = 1'b0;
			end
			oaa_pkg::OCT_NEGY_FLAT: begin
				fold_off = '0;                   fold_add = 1'b1; fold_neg = 1'b1;
			end
			oaa_pkg::OCT_NEGY_STEEP: begin
				fold_off = oaa_pkg::HALF_PI_Q61; fold_add = 1'b0; fold_neg = 1'b1;
			end
			oaa_pkg::OCT_NEGX_FLAT: begin
				fold_off = oaa_pkg::PI_Q61;      fold_add = 1'b0; fold_neg = 1'b0;
			end
			oaa_pkg::OCT_NEGX_STEEP: begin
				fold_off = oaa_pkg::HALF_PI_Q61; fold_add = 1'b1; fold_neg = 1'b0;
			end
			oaa_pkg::OCT_NEGXY_FLAT: begin
				fold_off = oaa_pkg::PI_Q61;      fold_add = 1'b0; fold_neg = 1'b1;
			end
			oaa_pkg::OCT_NEGXY_STEEP: begin
				fold_off = oaa_pkg::HALF_PI_Q61; fold_add = 1'b1; fold_neg = 1'b1;
			end
			default: begin
				fold_off = '0;                   fold_add = 1'b1; fold_neg = 1'b0;
			end
		endcase
		// p never exceeds pi/2, so the difference is already the magnitude
		fold_mag = fold_add ? (fold_off + {1'b0, p_s4}) : (fold_off - {1'b0, p_s4});
	end

	assign rnd = SUM_W'(mag_s5) + RND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= dv_vld_s[RW-1];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_vld_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1    <= dv_quo_s[RW-1];
			bq_s1   <= oaa_pkg::BQ_W'(oaa_pkg::COEF_B) * oaa_pkg::BQ_W'(dv_quo_s[RW-1]);
			oct_s1  <= dv_oct_s[RW-1];
			zero_s1 <= dv_zero_s[RW-1];

			r_s2    <= r_s1;
			t_s2    <= {oaa_pkg::COEF_A, oaa_pkg::RATIO_FRAC'(0)} - oaa_pkg::T_W'(bq_s1);
			oct_s2  <= oct_s1;
			zero_s2 <= zero_s1;

			ph_s3   <= PH_W'(t_s2[oaa_pkg::T_W-1:oaa_pkg::T_SPLIT]) * PH_W'(r_s2);
			pl_s3   <= PL_W'(t_s2[oaa_pkg::T_SPLIT-1:0]) * PL_W'(r_s2);
			oct_s3  <= oct_s2;
			zero_s3 <= zero_s2;

			p_s4    <= prod[oaa_pkg::PROD_W-1:1];
			oct_s4  <= oct_s3;
			zero_s4 <= zero_s3;

			mag_s5  <= zero_s4 ? '0 : fold_mag;
			neg_s5  <= zero_s4 ? 1'b0 : fold_neg;

			q_s6    <= rnd[SH +: AW];
			neg_s6  <= neg_s5;

			angle_q <= neg_s6 ? (AW'(0) - q_s6) : q_s6;
		end
	end

	assign result.valid = out_vld_q;
	assign result.angle = angle_q;

endmodule

FILE: rtl/core/octant_atan2_approximation.sv
// Top level of the octant atan2 block: front, queue and back part.
// Depends on oaa_pkg, oaa_coord_if, oaa_angle_if, oaa_front, oaa_queue, oaa_back.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------
//   coords   | in  | coord_y, coord_x (signed, W)    | valid/ready
//   result   | out | angle (signed Q2.F, 16 bits)    | valid/ready
//
// One item per cycle sustained while the result is not stalled; the divider
// stages, multipliers and queue are all pipelined. An item passes the front
// register, which loads at acceptance, then 1 queue slot, 17 divider stages
// (one quotient bit each), 6 polynomial/fold/round stages and the output
// register.
// Reset clears all valid bits and queue pointers; no clearing pass is needed.
// A stalled result holds the back part in place; the front keeps accepting
// until its register and the 2-entry queue are full.
module octant_atan2_approximation #(
	parameter int COORD_WIDTH     = oaa_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = oaa_pkg::ANGLE_FRAC_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	oaa_coord_if.sink   coords,
	oaa_angle_if.source result
);

	localparam int ITEM_W = 2 * COORD_WIDTH + 1 + $bits(oaa_pkg::oct_t);

	logic              fr_vld;
	logic              fr_rdy;
	logic [ITEM_W-1:0] fr_item;
	logic              bk_vld;
	logic              bk_rdy;
	logic [ITEM_W-1:0] bk_item;

	oaa_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.coords   (coords),
		.item_vld (fr_vld),
		.item_rdy (fr_rdy),
		.item     (fr_item)
	);

	oaa_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (oaa_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (fr_vld),
		.push_rdy  (fr_rdy),
		.push_data (fr_item),
		.pop_vld   (bk_vld),
		.pop_rdy   (bk_rdy),
		.pop_data  (bk_item)
	);

	oaa_back #(
		.COORD_WIDTH     (COORD_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_vld (bk_vld),
		.item_rdy (bk_rdy),
		.item     (bk_item),
		.result   (result)
	);

endmodule

FILE: rtl/core/oaa_checker.sv
// Port-level checker for the octant atan2 block, attached by bind.
// Depends on oaa_pkg and on the top level octant_atan2_approximation.
module oaa_checker #(
	parameter int ANGLE_FRAC_BITS = oaa_pkg::ANGLE_FRAC_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [oaa_pkg::ANGLE_W-1:0] angle
);

	// Front register, queue, divider, polynomial stages, output register
	localparam int CAP = 1 + oaa_pkg::QUEUE_DEPTH + oaa_pkg::RATIO_W + oaa_pkg::POLY_STAGES + 1;
	localparam int CW  = $clog2(CAP + 1) + 1;

	logic [CW-1:0] cnt_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CW'(in_acc) - CW'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_angle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(angle))
		else $error("angle changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result shown with no item outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAP))
		else $error("more items outstanding than the pipeline holds");

	if (ANGLE_FRAC_BITS <= 13) begin : g_range
		localparam int ANG_LIM =
			int'(oaa_pkg::PI_Q61 >> (oaa_pkg::Q61_FRAC - ANGLE_FRAC_BITS)) + 1;

		a_range: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid |-> ($signed(angle) <= ANG_LIM && $signed(angle) >= -ANG_LIM))
			else $error("angle outside [-pi, pi]");
	end

endmodule

bind octant_atan2_approximation oaa_checker #(
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_oaa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (coords.valid),
	.in_ready  (coords.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.angle     (result.angle)
);
